[hw/rtl/acbc_pkg.sv]
// ----------------------------------------------------------------------------
// acbc_pkg
// Shared types and constants of the active cell bitmap compactor.
// ----------------------------------------------------------------------------
package acbc_pkg;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;

  localparam int unsigned DIM_W   = 7;   // rows_in_use / columns_in_use
  localparam int unsigned COORD_W = 6;   // row / col
  localparam int unsigned ADDR_W  = 12;  // cell address and list index
  localparam int unsigned COUNT_W = 13;  // cell counts
  localparam int unsigned BIT_W   = 6;   // bit select inside a flag word
  localparam int unsigned WORD_W  = 1 << BIT_W;
  localparam int unsigned WORDS   = (1 << ADDR_W) / WORD_W;
  localparam int unsigned WIDX_W  = ADDR_W - BIT_W;
  localparam int unsigned CELLS   = 1 << ADDR_W;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_UPDATE,
    OP_READ,
    OP_REJECT
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_READ
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [ADDR_W-1:0] addr;      // cell address, or list index for a read
    logic [DIM_W-1:0]  scan_rows;
    logic [DIM_W-1:0]  scan_cols;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               changed;
    logic               out_of_range;
    logic [COUNT_W-1:0] count_current;
    logic [COUNT_W-1:0] count_pending;
  } res_t;

endpackage

[hw/rtl/acbc_front.sv]
// ----------------------------------------------------------------------------
// acbc_front
// Holds the grid shape registers, checks coordinates against the grid and
// turns each accepted item into a command for the back end.
// ----------------------------------------------------------------------------
module acbc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [acbc_pkg::DIM_W-1:0]        cfg_wdata_i,
  input  logic                              push_i,
  input  logic                              queue_full_i,
  input  logic [1:0]                        action_i,
  input  logic [acbc_pkg::COORD_W-1:0]      row_i,
  input  logic [acbc_pkg::COORD_W-1:0]      col_i,
  input  logic [acbc_pkg::ADDR_W-1:0]       entry_index_i,
  output logic                              cmd_push_o,
  output acbc_pkg::cmd_t                    cmd_o
);

  logic [acbc_pkg::DIM_W-1:0]   rows_q;
  logic [acbc_pkg::DIM_W-1:0]   cols_q;
  logic [acbc_pkg::DIM_W-1:0]   eff_rows;
  logic [acbc_pkg::DIM_W-1:0]   eff_cols;
  logic                         in_grid;
  logic [acbc_pkg::COUNT_W-1:0] cell_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= acbc_pkg::DIM_W'(acbc_pkg::MAX_ROWS);
      cols_q <= acbc_pkg::DIM_W'(acbc_pkg::MAX_COLS);
    end else if (cfg_we_i) begin
      if (acbc_pkg::cfg_reg_e'(cfg_index_i) == acbc_pkg::REG_ROWS) begin
        rows_q <= cfg_wdata_i;
      end else begin
        cols_q <= cfg_wdata_i;
      end
    end
  end

  // values above the grid size saturate
  assign eff_rows = (rows_q > acbc_pkg::DIM_W'(acbc_pkg::MAX_ROWS)) ?
                    acbc_pkg::DIM_W'(acbc_pkg::MAX_ROWS) : rows_q;
  assign eff_cols = (cols_q > acbc_pkg::DIM_W'(acbc_pkg::MAX_COLS)) ?
                    acbc_pkg::DIM_W'(acbc_pkg::MAX_COLS) : cols_q;

  assign in_grid = ({1'b0, row_i} < eff_rows) && ({1'b0, col_i} < eff_cols);

  // row-major with a stride of the configured column count
  assign cell_addr = acbc_pkg::COUNT_W'(row_i) * acbc_pkg::COUNT_W'(eff_cols)
                   + acbc_pkg::COUNT_W'(col_i);

  assign cmd_push_o = push_i && !queue_full_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.scan_rows = eff_rows;
    cmd_o.scan_cols = eff_cols;
    cmd_o.addr      = cell_addr[acbc_pkg::ADDR_W-1:0];
    unique case (acbc_pkg::action_e'(action_i))
      acbc_pkg::ACT_ADD: begin
        cmd_o.op = in_grid ? acbc_pkg::OP_ADD : acbc_pkg::OP_REJECT;
      end
      acbc_pkg::ACT_REMOVE: begin
        cmd_o.op = in_grid ? acbc_pkg::OP_REMOVE : acbc_pkg::OP_REJECT;
      end
      acbc_pkg::ACT_UPDATE: begin
        cmd_o.op = acbc_pkg::OP_UPDATE;
      end
      acbc_pkg::ACT_READ: begin
        cmd_o.op   = acbc_pkg::OP_READ;
        cmd_o.addr = entry_index_i;
      end
      default: begin
        cmd_o.op = acbc_pkg::OP_REJECT;
      end
    endcase
  end

endmodule

[hw/rtl/acbc_cmd_queue.sv]
// ----------------------------------------------------------------------------
// acbc_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module acbc_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  acbc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output acbc_pkg::cmd_t data_o
);

  acbc_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/acbc_res_queue.sv]
// ----------------------------------------------------------------------------
// acbc_res_queue
// Two-entry result queue that decouples the back end from the receiver.
// ----------------------------------------------------------------------------
module acbc_res_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  acbc_pkg::res_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output acbc_pkg::res_t data_o
);

  acbc_pkg::res_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/acbc_back.sv]
// ----------------------------------------------------------------------------
// acbc_back
// Executes commands: flag read-modify-write, list rebuild scan and list
// reads. Owns the flag map, the compacted list and the two counters.
// ----------------------------------------------------------------------------
module acbc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  acbc_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_space_i,
  output logic           res_push_o,
  output acbc_pkg::res_t res_o
);

  localparam int unsigned AW = acbc_pkg::ADDR_W;
  localparam int unsigned CW = acbc_pkg::COUNT_W;
  localparam int unsigned PW = acbc_pkg::COORD_W;
  localparam int unsigned WW = acbc_pkg::WORD_W;
  localparam int unsigned XW = acbc_pkg::WIDX_W;
  localparam int unsigned BW = acbc_pkg::BIT_W;

  // flag map as words of flags, one valid bit per word stands in for reset
  logic [WW-1:0]       flag_mem [acbc_pkg::WORDS];
  logic [acbc_pkg::WORDS-1:0] word_vld_q;
  logic [WW-1:0]       flag_rd_q;
  logic                flag_vld_rd_q;
  logic                flag_rd_en;
  logic [XW-1:0]       flag_rd_addr;
  logic                flag_we;
  logic [WW-1:0]       flag_wdata;
  logic [WW-1:0]       word;
  logic [WW-1:0]       mask;

  // compacted list, each entry holds row and column
  logic [2*PW-1:0]     list_mem [acbc_pkg::CELLS];
  logic [2*PW-1:0]     list_rd_q;
  logic                list_rd_en;
  logic                list_we;
  logic [2*PW-1:0]     list_wdata;

  acbc_pkg::back_state_e state_q, state_d;
  acbc_pkg::cmd_t        cur_q, cur_d;
  logic [CW-1:0]         pending_q, pending_d;
  logic [CW-1:0]         current_q, current_d;

  // scan issue side
  logic                  issuing_q, issuing_d;
  logic [PW-1:0]         sr_q, sr_d;
  logic [PW-1:0]         sc_q, sc_d;
  logic [AW-1:0]         sa_q, sa_d;
  // scan check side, in the cycle after the issue
  logic                  p_vld_q, p_vld_d;
  logic [PW-1:0]         p_r_q, p_r_d;
  logic [PW-1:0]         p_c_q, p_c_d;
  logic [BW-1:0]         p_bit_q, p_bit_d;
  logic [CW-1:0]         n_q, n_d;

  assign word = flag_vld_rd_q ? flag_rd_q : '0;
  assign mask = WW'(1) << cur_q.addr[BW-1:0];

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    pending_d    = pending_q;
    current_d    = current_q;
    issuing_d    = issuing_q;
    sr_d         = sr_q;
    sc_d         = sc_q;
    sa_d         = sa_q;
    p_vld_d      = 1'b0;
    p_r_d        = p_r_q;
    p_c_d        = p_c_q;
    p_bit_d      = p_bit_q;
    n_d          = n_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '0;
    res_o.count_current = current_q;
    res_o.count_pending = pending_q;
    flag_rd_en   = 1'b0;
    flag_rd_addr = cmd_i.addr[AW-1:BW];
    flag_we      = 1'b0;
    flag_wdata   = word;
    list_rd_en   = 1'b0;
    list_we      = 1'b0;
    list_wdata   = {p_r_q, p_c_q};

    unique case (state_q)
      acbc_pkg::ST_IDLE: begin
        if (cmd_valid_i && res_space_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          unique case (cmd_i.op) inside
            acbc_pkg::OP_ADD, acbc_pkg::OP_REMOVE: begin
              flag_rd_en = 1'b1;
              state_d    = acbc_pkg::ST_RMW;
            end
            acbc_pkg::OP_UPDATE: begin
              current_d = pending_q;
              n_d       = '0;
              sr_d      = '0;
              sc_d      = '0;
              sa_d      = '0;
              if (cmd_i.scan_rows != '0 && cmd_i.scan_cols != '0) begin
                issuing_d = 1'b1;
                state_d   = acbc_pkg::ST_SCAN;
              end else begin
                res_push_o          = 1'b1;
                res_o.count_current = pending_q;
              end
            end
            acbc_pkg::OP_READ: begin
              if ({1'b0, cmd_i.addr} < current_q) begin
                list_rd_en = 1'b1;
                state_d    = acbc_pkg::ST_READ;
              end else begin
                res_push_o         = 1'b1;
                res_o.out_of_range = 1'b1;
              end
            end
            default: begin
              res_push_o         = 1'b1;
              res_o.out_of_range = 1'b1;
            end
          endcase
        end
      end

      acbc_pkg::ST_RMW: begin
        res_push_o = 1'b1;
        state_d    = acbc_pkg::ST_IDLE;
        if (cur_q.op == acbc_pkg::OP_ADD) begin
          if ((word & mask) == '0) begin
            flag_we             = 1'b1;
            flag_wdata          = word | mask;
            pending_d           = pending_q + CW'(1);
            res_o.changed       = 1'b1;
            res_o.count_pending = pending_d;
          end
        end else begin
          if ((word & mask) != '0) begin
            flag_we             = 1'b1;
            flag_wdata          = word & ~mask;
            pending_d           = pending_q - CW'(1);
            res_o.changed       = 1'b1;
            res_o.count_pending = pending_d;
          end
        end
      end

      acbc_pkg::ST_SCAN: begin
        // issue one cell per cycle in row-major order
        if (issuing_q) begin
          flag_rd_en   = 1'b1;
          flag_rd_addr = sa_q[AW-1:BW];
          p_vld_d      = 1'b1;
          p_r_d        = sr_q;
          p_c_d        = sc_q;
          p_bit_d      = sa_q[BW-1:0];
          sa_d         = sa_q + AW'(1);
          if ({1'b0, sc_q} == cur_q.scan_cols - acbc_pkg::DIM_W'(1)) begin
            sc_d = '0;
            sr_d = sr_q + PW'(1);
            if ({1'b0, sr_q} == cur_q.scan_rows - acbc_pkg::DIM_W'(1)) begin
              issuing_d = 1'b0;
            end
          end else begin
            sc_d = sc_q + PW'(1);
          end
        end
        // append set cells while the list is short of the count
        if (p_vld_q && word[p_bit_q] && (n_q < current_q)) begin
          list_we = 1'b1;
          n_d     = n_q + CW'(1);
        end
        if (!issuing_q && !p_vld_q) begin
          res_push_o = 1'b1;
          state_d    = acbc_pkg::ST_IDLE;
        end
      end

      acbc_pkg::ST_READ: begin
        res_push_o     = 1'b1;
        res_o.cell_row = list_rd_q[2*PW-1:PW];
        res_o.cell_col = list_rd_q[PW-1:0];
        res_o.changed  = 1'b1;
        state_d        = acbc_pkg::ST_IDLE;
      end

      default: begin
        state_d = acbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= acbc_pkg::ST_IDLE;
      pending_q     <= '0;
      current_q     <= '0;
      issuing_q     <= 1'b0;
      p_vld_q       <= 1'b0;
      n_q           <= '0;
      word_vld_q    <= '0;
      flag_vld_rd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      current_q <= current_d;
      issuing_q <= issuing_d;
      p_vld_q   <= p_vld_d;
      n_q       <= n_d;
      if (flag_rd_en) begin
        flag_vld_rd_q <= word_vld_q[flag_rd_addr];
      end
      if (flag_we) begin
        word_vld_q[cur_q.addr[AW-1:BW]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    sr_q    <= sr_d;
    sc_q    <= sc_d;
    sa_q    <= sa_d;
    p_r_q   <= p_r_d;
    p_c_q   <= p_c_d;
    p_bit_q <= p_bit_d;
  end

  always_ff @(posedge clk_i) begin
    if (flag_rd_en) begin
      flag_rd_q <= flag_mem[flag_rd_addr];
    end
    if (flag_we) begin
      flag_mem[cur_q.addr[AW-1:BW]] <= flag_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_rd_en) begin
      list_rd_q <= list_mem[cmd_i.addr];
    end
    if (list_we) begin
      list_mem[n_q[AW-1:0]] <= list_wdata;
    end
  end

endmodule

[hw/rtl/active_cell_bitmap_compactor_top.sv]
// ----------------------------------------------------------------------------
// active_cell_bitmap_compactor_top
// Active cell tracker for a 2D grid with a compacted list of set cells.
// ----------------------------------------------------------------------------
// Items enter through push/full and results leave through empty/pop; every
// item gives exactly one result, in order. Each action adds, removes, rebuilds
// the list (update) or reads a list entry. The grid shape is set through the
// plain write port (index 0 rows, index 1 columns) while the block is idle.
// Keeping to this is up to the user. A front stage checks coordinates and
// forms the cell address, a two-entry command queue feeds the back end, and a
// two-entry result queue holds finished results so new items are taken while
// the receiver stalls. Add, remove and read are bound by the registered read
// of the flag map or list memory followed by the write back or result push;
// an add or remove outside the grid, or a read past the list, is answered
// straight from idle. The back end takes the next command only once it is
// back in idle. An update scans rows * columns flags, one flag per cycle.
// Reset clears both counters, the queues and a valid bit per flag word, so
// the flag map reads as all clear at once; no clearing pass is needed.
// When the result queue is full the back end holds and, once the command
// queue fills, full rises and stays high until the receiver pops.
// ----------------------------------------------------------------------------
module active_cell_bitmap_compactor_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [acbc_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          action_i,
  input  logic [acbc_pkg::COORD_W-1:0]        row_i,
  input  logic [acbc_pkg::COORD_W-1:0]        col_i,
  input  logic [acbc_pkg::ADDR_W-1:0]         entry_index_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [acbc_pkg::COORD_W-1:0]        cell_row_o,
  output logic [acbc_pkg::COORD_W-1:0]        cell_col_o,
  output logic                                changed_o,
  output logic                                out_of_range_o,
  output logic [acbc_pkg::COUNT_W-1:0]        count_current_o,
  output logic [acbc_pkg::COUNT_W-1:0]        count_pending_o
);

  acbc_pkg::cmd_t front_cmd;
  acbc_pkg::cmd_t queue_cmd;
  acbc_pkg::res_t back_res;
  acbc_pkg::res_t head_res;
  logic           cmd_push;
  logic           cmd_empty;
  logic           cmd_pop;
  logic           res_push;
  logic           res_full;

  acbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .queue_full_i  (full),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .entry_index_i (entry_index_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (front_cmd)
  );

  acbc_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (queue_cmd)
  );

  acbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_space_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  acbc_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_res)
  );

  assign cell_row_o      = head_res.cell_row;
  assign cell_col_o      = head_res.cell_col;
  assign changed_o       = head_res.changed;
  assign out_of_range_o  = head_res.out_of_range;
  assign count_current_o = head_res.count_current;
  assign count_pending_o = head_res.count_pending;

endmodule
